/* design/mrs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrs_pkg
// Shared constants, types and the byte-wise crc step of the rtu slave engine.
// ----------------------------------------------------------------------------
package mrs_pkg;

  localparam int TABLE_WORDS_DEF    = 64;
  localparam int MAX_READ_WORDS_DEF = 16;
  localparam int FRAME_BYTES_DEF    = 64;

  // frame length field wide enough for the largest frame buffer
  localparam int JOB_NW = 7;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [7:0] ADDR_BCAST      = 8'd255;
  localparam logic [7:0] FN_READ_HOLD    = 8'd3;
  localparam logic [7:0] FN_READ_INPUT   = 8'd4;
  localparam logic [7:0] FN_WRITE_SINGLE = 8'd6;
  localparam logic [7:0] FN_EXC_FLAG     = 8'b1000_0000;
  localparam logic [7:0] EXC_FUNCTION    = 8'h01;
  localparam logic [7:0] EXC_ADDRESS     = 8'h02;

  localparam logic [7:0] REG_SLAVE_ADDR = 8'd0;
  localparam logic [7:0] REG_GAP_TICKS  = 8'd1;

  localparam logic CMD_BYTE = 1'b0;

  typedef struct packed {
    logic              valid;
    logic [JOB_NW-1:0] n;
  } job_t;

  typedef struct packed {
    logic busy;
    logic take;
  } bk_stat_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] w;
    w = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (w[0]) w = (w >> 1) ^ CRC_POLY;
      else      w = w >> 1;
    end
    return w;
  endfunction

endpackage

/* design/mrs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrs_ram
// Generic single write, single read port ram with registered read data.
// ----------------------------------------------------------------------------
module mrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

/* design/mrs_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrs_front
// Takes bytes and ticks, fills the frame buffer and hands finished frames on.
// ----------------------------------------------------------------------------
module mrs_front #(
  parameter int FRAME_BYTES = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic                           cmd,
  input  logic [7:0]                     rx_byte,
  input  logic [7:0]                     gap_ticks,
  input  mrs_pkg::bk_stat_t              stat,
  output mrs_pkg::job_t                  job,
  output logic                           fs_we,
  output logic [$clog2(FRAME_BYTES)-1:0] fs_waddr,
  output logic [7:0]                     fs_wdata
);
  import mrs_pkg::*;

  localparam int CW = $clog2(FRAME_BYTES);

  logic [CW-1:0] count;
  logic [CW-1:0] slot;
  logic [15:0]   idle;
  logic          frame_end;

  assign slot      = (count > CW'(FRAME_BYTES - 2)) ? '0 : count;
  assign frame_end = accept && (cmd != CMD_BYTE) && (idle > {8'h00, gap_ticks}) &&
                     (count > CW'(1));

  assign fs_we    = accept && (cmd == CMD_BYTE);
  assign fs_waddr = slot;
  assign fs_wdata = rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      idle      <= '0;
      job.valid <= 1'b0;
      job.n     <= '0;
    end else begin
      if (stat.take) job.valid <= 1'b0;
      if (accept) begin
        if (cmd == CMD_BYTE) begin
          idle  <= '0;
          count <= slot + CW'(1);
        end else if (frame_end) begin
          idle      <= 16'hFFFF;
          count     <= '0;
          job.valid <= 1'b1;
          job.n     <= JOB_NW'(count);
        end else begin
          idle <= idle + 16'd1;
        end
      end
    end
  end

endmodule

/* design/mrs_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrs_back
// Checks a finished frame, runs the function and streams the reply bytes.
// ----------------------------------------------------------------------------
module mrs_back #(
  parameter int TABLE_WORDS    = 64,
  parameter int MAX_READ_WORDS = 16,
  parameter int FRAME_BYTES    = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  mrs_pkg::job_t                  job,
  output mrs_pkg::bk_stat_t              stat,
  input  logic [7:0]                     slave_address,
  output logic                           fs_re,
  output logic [$clog2(FRAME_BYTES)-1:0] fs_raddr,
  input  logic [7:0]                     fs_rdata,
  input  logic                           pop,
  output logic                           empty,
  output logic [7:0]                     tx_byte,
  output logic                           last_byte
);
  import mrs_pkg::*;

  localparam int CW = $clog2(FRAME_BYTES);
  localparam int AW = $clog2(TABLE_WORDS);
  localparam int RW = $clog2(MAX_READ_WORDS + 1);

  typedef enum logic [3:0] {
    IDLE, CK_ADDR, CK_DATA, DECIDE, HDR, W_ADDR, W_DATA, W_HI, W_LO,
    CRC_LO, CRC_HI, E_ADDR, E_DATA
  } st_t;

  st_t              st;
  logic [CW-1:0]    n;
  logic [CW-1:0]    j;
  logic [15:0]      crc;
  logic [7:0]       b0, b1, b2, b3, b4, b5, prevb, lastb;
  logic [7:0]       hb1, hb2;
  logic             is_read;
  logic [1:0]       hidx;
  logic [AW-1:0]    waddr;
  logic [RW-1:0]    rem;
  logic [15:0]      word;
  logic             tv_q;
  logic [TABLE_WORDS-1:0] tvalid;
  logic             out_valid;

  logic [15:0] hi_w, lo_w;
  logic [16:0] rd_end;
  logic        frame_ok, rd_ok, wr_ok;
  logic        tbl_we, tbl_re;
  logic [15:0] tbl_rdata;
  logic        out_free;
  logic [7:0]  hdr_byte;

  assign hi_w     = {b2, b3};
  assign lo_w     = {b4, b5};
  assign rd_end   = {1'b0, hi_w} + {1'b0, lo_w};
  assign rd_ok    = (rd_end <= 17'(TABLE_WORDS)) && (lo_w <= 16'(MAX_READ_WORDS));
  assign wr_ok    = hi_w < 16'(TABLE_WORDS);
  assign frame_ok = (n > CW'(5)) && (b0 != 8'h00) &&
                    ((b0 == slave_address) || (b0 == ADDR_BCAST)) &&
                    (crc == {lastb, prevb});

  assign stat.take = (st == IDLE) && job.valid;
  assign stat.busy = (st != IDLE);

  assign fs_re    = (st == CK_ADDR) || (st == E_ADDR);
  assign fs_raddr = j;
  assign tbl_re   = (st == W_ADDR);
  assign tbl_we   = (st == DECIDE) && frame_ok && (b1 == FN_WRITE_SINGLE) && wr_ok;

  assign out_free = !out_valid;
  assign empty    = !out_valid;

  always_comb begin
    case (hidx)
      2'd0:    hdr_byte = b0;
      2'd1:    hdr_byte = hb1;
      default: hdr_byte = hb2;
    endcase
  end

  mrs_ram #(.WIDTH(16), .DEPTH(TABLE_WORDS)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (hi_w[AW-1:0]),
    .wdata (lo_w),
    .re    (tbl_re),
    .raddr (waddr),
    .rdata (tbl_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= IDLE;
      out_valid <= 1'b0;
      tvalid    <= '0;
    end else begin
      if (out_valid && pop) out_valid <= 1'b0;
      if (tbl_we) tvalid[hi_w[AW-1:0]] <= 1'b1;
      case (st)
        IDLE: begin
          if (job.valid) begin
            n   <= CW'(job.n);
            j   <= '0;
            crc <= CRC_INIT;
            st  <= CK_ADDR;
          end
        end
        CK_ADDR: st <= CK_DATA;
        CK_DATA: begin
          if (({1'b0, j} + (CW+1)'(2)) < {1'b0, n}) crc <= crc_byte(crc, fs_rdata);
          case (j)
            CW'(0):  b0 <= fs_rdata;
            CW'(1):  b1 <= fs_rdata;
            CW'(2):  b2 <= fs_rdata;
            CW'(3):  b3 <= fs_rdata;
            CW'(4):  b4 <= fs_rdata;
            CW'(5):  b5 <= fs_rdata;
            default: ;
          endcase
          prevb <= lastb;
          lastb <= fs_rdata;
          if (j == n - CW'(1)) begin
            st <= DECIDE;
          end else begin
            j  <= j + CW'(1);
            st <= CK_ADDR;
          end
        end
        DECIDE: begin
          crc     <= CRC_INIT;
          hidx    <= 2'd0;
          j       <= '0;
          is_read <= 1'b0;
          waddr   <= hi_w[AW-1:0];
          rem     <= RW'(lo_w);
          if (!frame_ok) begin
            st <= IDLE;
          end else if (b1 == FN_READ_HOLD || b1 == FN_READ_INPUT) begin
            st <= HDR;
            if (rd_ok) begin
              is_read <= 1'b1;
              hb1     <= b1;
              hb2     <= {b5[6:0], 1'b0};
            end else begin
              hb1 <= b1 | FN_EXC_FLAG;
              hb2 <= EXC_ADDRESS;
            end
          end else if (b1 == FN_WRITE_SINGLE) begin
            if (wr_ok) begin
              st <= E_ADDR;
            end else begin
              hb1 <= b1 | FN_EXC_FLAG;
              hb2 <= EXC_ADDRESS;
              st  <= HDR;
            end
          end else begin
            hb1 <= b1 | FN_EXC_FLAG;
            hb2 <= EXC_FUNCTION;
            st  <= HDR;
          end
        end
        HDR: begin
          if (out_free) begin
            out_valid <= 1'b1;
            tx_byte   <= hdr_byte;
            last_byte <= 1'b0;
            crc       <= crc_byte(crc, hdr_byte);
            hidx      <= hidx + 2'd1;
            if (hidx == 2'd2) st <= (is_read && rem != '0) ? W_ADDR : CRC_LO;
          end
        end
        W_ADDR: begin
          tv_q <= tvalid[waddr];
          st   <= W_DATA;
        end
        W_DATA: begin
          // never-written words read as zero
          word <= tv_q ? tbl_rdata : 16'h0000;
          st   <= W_HI;
        end
        W_HI: begin
          if (out_free) begin
            out_valid <= 1'b1;
            tx_byte   <= word[15:8];
            last_byte <= 1'b0;
            crc       <= crc_byte(crc, word[15:8]);
            st        <= W_LO;
          end
        end
        W_LO: begin
          if (out_free) begin
            out_valid <= 1'b1;
            tx_byte   <= word[7:0];
            last_byte <= 1'b0;
            crc       <= crc_byte(crc, word[7:0]);
            waddr     <= waddr + AW'(1);
            rem       <= rem - RW'(1);
            st        <= (rem == RW'(1)) ? CRC_LO : W_ADDR;
          end
        end
        CRC_LO: begin
          if (out_free) begin
            out_valid <= 1'b1;
            tx_byte   <= crc[7:0];
            last_byte <= 1'b0;
            st        <= CRC_HI;
          end
        end
        CRC_HI: begin
          if (out_free) begin
            out_valid <= 1'b1;
            tx_byte   <= crc[15:8];
            last_byte <= 1'b1;
            st        <= IDLE;
          end
        end
        // echo of a good frame carries its own valid crc
        E_ADDR: st <= E_DATA;
        E_DATA: begin
          if (out_free) begin
            out_valid <= 1'b1;
            tx_byte   <= fs_rdata;
            last_byte <= (j == n - CW'(1));
            if (j == n - CW'(1)) begin
              st <= IDLE;
            end else begin
              j  <= j + CW'(1);
              st <= E_ADDR;
            end
          end
        end
        default: st <= IDLE;
      endcase
    end
  end

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    stat.take |-> (st == IDLE))
    else $error("job taken while back end busy");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_byte && !$past(out_valid)) |-> (st == IDLE))
    else $error("final reply byte without return to idle");

  a_tbl_range: assert property (@(posedge clk) disable iff (rst)
    tbl_we |-> (hi_w < 16'(TABLE_WORDS)))
    else $error("table write out of range");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> (out_valid && $stable(tx_byte) && $stable(last_byte)))
    else $error("pending reply byte overwritten");

endmodule

/* design/modbus_rtu_slave_engine_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_slave_engine_unit
// Rtu slave: frames received bytes by tick gaps, answers read and write
// requests from a word table with crc-terminated replies.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  input    | push / full        | cmd, rx_byte
//  result   | pop / empty        | tx_byte, last_byte
//  config   | cfg_valid/ready    | cfg_index, cfg_data
//
//  the front end takes a byte or a plain tick whenever push is high and full is low
//  a frame end ties up the back end: each frame byte is read back for the crc
//  check, then the reply bytes are built and streamed, each table word read first
//  full stays high while a frame is checked or its reply is built
//  reset is synchronous; the word table reads zero until written
//  a stalled result holds the back end, and through full the front end, until the back end is idle
// ----------------------------------------------------------------------------
module modbus_rtu_slave_engine_unit #(
  parameter int TABLE_WORDS    = mrs_pkg::TABLE_WORDS_DEF,
  parameter int MAX_READ_WORDS = mrs_pkg::MAX_READ_WORDS_DEF,
  parameter int FRAME_BYTES    = mrs_pkg::FRAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       cmd,
  input  logic [7:0] rx_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] tx_byte,
  output logic       last_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import mrs_pkg::*;

  localparam int CW = $clog2(FRAME_BYTES);

  logic [7:0]    slave_address;
  logic [7:0]    gap_ticks;
  job_t          job;
  bk_stat_t      stat;
  logic          fs_we, fs_re;
  logic [CW-1:0] fs_waddr, fs_raddr;
  logic [7:0]    fs_wdata, fs_rdata;
  logic          accept;

  assign cfg_ready = 1'b1;
  assign full      = job.valid || stat.busy;
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= 8'd1;
      gap_ticks     <= 8'd3;
    end else if (cfg_valid) begin
      if (cfg_index == REG_SLAVE_ADDR) slave_address <= cfg_data;
      if (cfg_index == REG_GAP_TICKS)  gap_ticks     <= cfg_data;
    end
  end

  mrs_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame (
    .clk   (clk),
    .we    (fs_we),
    .waddr (fs_waddr),
    .wdata (fs_wdata),
    .re    (fs_re),
    .raddr (fs_raddr),
    .rdata (fs_rdata)
  );

  mrs_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .cmd       (cmd),
    .rx_byte   (rx_byte),
    .gap_ticks (gap_ticks),
    .stat      (stat),
    .job       (job),
    .fs_we     (fs_we),
    .fs_waddr  (fs_waddr),
    .fs_wdata  (fs_wdata)
  );

  mrs_back #(
    .TABLE_WORDS    (TABLE_WORDS),
    .MAX_READ_WORDS (MAX_READ_WORDS),
    .FRAME_BYTES    (FRAME_BYTES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .job           (job),
    .stat          (stat),
    .slave_address (slave_address),
    .fs_re         (fs_re),
    .fs_raddr      (fs_raddr),
    .fs_rdata      (fs_rdata),
    .pop           (pop),
    .empty         (empty),
    .tx_byte       (tx_byte),
    .last_byte     (last_byte)
  );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rtu slave engine: builds request frames and
// silence ticks, predicts each reply byte, and compares every popped byte.
// ----------------------------------------------------------------------------
module tb;
  import mrs_pkg::*;

  localparam int TBL = 64;
  localparam int MAXRD = 16;
  localparam int FRB = 64;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
  } rx_item_t;

  typedef struct packed {
    logic [7:0] tx;
    logic       last;
  } reply_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic cmd = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic empty;
  logic pop = 1'b0;
  logic [7:0] tx_byte;
  logic last_byte;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = 8'h00;
  logic [7:0] cfg_data = 8'h00;

  modbus_rtu_slave_engine_unit dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .cmd(cmd), .rx_byte(rx_byte),
    .empty(empty), .pop(pop), .tx_byte(tx_byte), .last_byte(last_byte),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // predicted state of the slave
  logic [7:0]  p_frame[FRB];
  logic [6:0]  p_count;
  logic [15:0] p_idle;
  logic [15:0] p_table[TBL];
  logic [7:0]  p_addr;
  logic [7:0]  p_gap;

  rx_item_t    pending_rx[$];
  reply_byte_t reply_expect[$];
  int          errors = 0;
  int          send_idle_pct = 6;
  int          recv_idle_pct = 74;
  bit          hold_go = 1'b0;
  int          hold_cnt = 0;
  logic        recv_hold;
  bit          gen_done = 1'b0;
  int          quiet_cycles = 0;

  // acceptance seen at the rising edge, used by the driver on the next falling edge
  logic full_s = 1'b1;

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  function automatic logic [15:0] crc_of(input logic [7:0] b[64], input int len);
    logic [15:0] w;
    w = 16'hFFFF;
    for (int i = 0; i < len; i++) begin
      w = w ^ {8'h00, b[i]};
      for (int k = 0; k < 8; k++) w = w[0] ? ((w >> 1) ^ 16'hA001) : (w >> 1);
    end
    return w;
  endfunction

  task automatic predict_reply(input rx_item_t it);
    logic [15:0] old, crc;
    logic [7:0]  rep[64];
    int n, len, hi, lo;
    if (it.cmd == CMD_BYTE) begin
      p_idle = 16'h0;
      if (p_count > FRB - 2) p_count = '0;
      p_frame[p_count] = it.data;
      p_count++;
      return;
    end
    old = p_idle;
    p_idle = old + 16'd1;
    if (!(old > {8'h00, p_gap} && p_count > 1)) return;
    n = int'(p_count);
    p_count = '0;
    p_idle = 16'hFFFF;
    if (p_frame[0] == 8'h00 || n <= 5 || (p_frame[0] != p_addr && p_frame[0] != ADDR_BCAST))
      return;
    crc = crc_of(p_frame, n - 2);
    if (p_frame[n-2] != crc[7:0] || p_frame[n-1] != crc[15:8]) return;
    rep = p_frame;
    hi = int'({rep[2], rep[3]});
    lo = int'({rep[4], rep[5]});
    len = 5;
    if (rep[1] == FN_READ_HOLD || rep[1] == FN_READ_INPUT) begin
      if (hi + lo <= TBL && lo <= MAXRD) begin
        for (int i = 0; i < lo; i++) begin
          rep[3+2*i] = p_table[hi+i][15:8];
          rep[4+2*i] = p_table[hi+i][7:0];
        end
        rep[2] = 8'(lo * 2);
        len = lo * 2 + 5;
      end else begin
        rep[1] = rep[1] | FN_EXC_FLAG;
        rep[2] = EXC_ADDRESS;
      end
    end else if (rep[1] == FN_WRITE_SINGLE) begin
      if (hi < TBL) begin
        p_table[hi] = 16'(lo);
        len = n;
      end else begin
        rep[1] = rep[1] | FN_EXC_FLAG;
        rep[2] = EXC_ADDRESS;
      end
    end else begin
      rep[1] = rep[1] | FN_EXC_FLAG;
      rep[2] = EXC_FUNCTION;
    end
    crc = crc_of(rep, len - 2);
    rep[len-2] = crc[7:0];
    rep[len-1] = crc[15:8];
    for (int i = 0; i < len; i++) reply_expect.push_back('{tx: rep[i], last: (i == len - 1)});
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full_s) begin
        predict_reply('{cmd: cmd, data: rx_byte});
        void'(pending_rx.pop_front());
      end
      if (pending_rx.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        push <= 1'b1;
        cmd <= pending_rx[0].cmd;
        rx_byte <= pending_rx[0].data;
      end else begin
        push <= 1'b0;
        cmd <= 1'($urandom_range(1));
        rx_byte <= 8'($urandom_range(255));
      end
    end
  end

  always @(posedge clk) full_s <= full;

  // monitor
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (reply_expect.size() == 0) begin
        report("unexpected byte", tx_byte, 8'h00);
      end else begin
        if (tx_byte !== reply_expect[0].tx) report("tx_byte", tx_byte, reply_expect[0].tx);
        if (last_byte !== reply_expect[0].last)
          report("last_byte", {7'h0, last_byte}, {7'h0, reply_expect[0].last});
        void'(reply_expect.pop_front());
      end
    end
  end

  // long receiver hold, counted here once started
  assign recv_hold = hold_go && (hold_cnt < HOLD_CYCLES);

  always @(posedge clk) begin
    if (recv_hold) hold_cnt <= hold_cnt + 1;
  end

  always @(negedge clk) begin
    pop <= !rst && !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || rst || gen_done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic add_byte(input logic [7:0] b);
    pending_rx.push_back('{cmd: ~CMD_BYTE, data: 8'h00});
    pending_rx[$] = '{cmd: CMD_BYTE, data: b};
  endtask

  task automatic add_ticks(input int k);
    for (int i = 0; i < k; i++) pending_rx.push_back('{cmd: ~CMD_BYTE, data: 8'($urandom_range(255))});
  endtask

  // queue a framed request with correct or broken crc, then end it with silence
  task automatic add_frame(input logic [7:0] b[64], input int body, input bit bad_crc,
                           input int gap);
    logic [15:0] c;
    c = crc_of(b, body);
    if (bad_crc) c = c ^ 16'h0100;
    for (int i = 0; i < body; i++) add_byte(b[i]);
    add_byte(c[7:0]);
    add_byte(c[15:8]);
    add_ticks(gap + 2);
  endtask

  task automatic add_request(input logic [7:0] a, input logic [7:0] fn, input logic [15:0] x,
                             input logic [15:0] y, input int gap);
    logic [7:0] b[64];
    b[0] = a; b[1] = fn; b[2] = x[15:8]; b[3] = x[7:0]; b[4] = y[15:8]; b[5] = y[7:0];
    add_frame(b, 6, 1'b0, gap);
  endtask

  task automatic wait_drained();
    while (pending_rx.size() != 0 || reply_expect.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_SLAVE_ADDR) p_addr = val;
    else p_gap = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_random(input int count, input int gap);
    logic [7:0] b[64];
    int body, sel;
    for (int k = 0; k < count; k++) begin
      sel = int'($urandom_range(99));
      b[0] = ($urandom_range(9) == 0) ? ADDR_BCAST : p_addr;
      if ($urandom_range(19) == 0) b[0] = 8'($urandom_range(255));
      b[1] = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) :
             (sel < 40 ? FN_READ_HOLD : sel < 60 ? FN_READ_INPUT : FN_WRITE_SINGLE);
      b[2] = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'h00;
      b[3] = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(63));
      b[4] = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'h00;
      b[5] = (b[1] == FN_WRITE_SINGLE) ? 8'($urandom_range(255)) : 8'($urandom_range(17));
      body = 6;
      if ($urandom_range(9) == 0) body = int'($urandom_range(2, 20));
      else if (b[1] == FN_WRITE_SINGLE && $urandom_range(3) == 0)
        body = int'($urandom_range(7, 12));
      for (int i = 6; i < body; i++) b[i] = 8'($urandom_range(255));
      if (sel >= 95) begin
        add_byte(8'($urandom_range(255)));
        add_ticks(int'($urandom_range(gap + 3)));
      end else begin
        add_frame(b, body, ($urandom_range(14) == 0), gap);
      end
    end
  endtask

  initial begin
    logic [7:0] b[64];
    for (int i = 0; i < TBL; i++) p_table[i] = 16'h0;
    for (int i = 0; i < FRB; i++) p_frame[i] = 8'h00;
    p_count = '0; p_idle = '0; p_addr = 8'd1; p_gap = 8'd3;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reads at the table edges, writes, exceptions, rejected frames
    add_request(8'd1, FN_READ_HOLD, 16'd0, 16'd0, 3);
    add_request(8'd1, FN_WRITE_SINGLE, 16'd63, 16'hFFFF, 3);
    add_request(ADDR_BCAST, FN_WRITE_SINGLE, 16'd0, 16'h8001, 3);
    add_request(8'd1, FN_READ_INPUT, 16'd48, 16'd16, 3);
    add_request(8'd1, FN_READ_HOLD, 16'd0, 16'd17, 3);
    add_request(8'd1, FN_WRITE_SINGLE, 16'd64, 16'd5, 3);
    add_request(8'd1, 8'hFF, 16'd0, 16'd0, 3);
    b[0] = 8'd1; b[1] = FN_READ_HOLD; b[2] = 8'h00; b[3] = 8'h00; b[4] = 8'h00; b[5] = 8'h01;
    add_frame(b, 6, 1'b1, 3);
    add_frame(b, 2, 1'b0, 3);
    // long write frame echoed whole, then an overrun that wraps the count
    for (int i = 6; i < 10; i++) b[i] = 8'($urandom_range(255));
    b[1] = FN_WRITE_SINGLE; b[3] = 8'd5;
    add_frame(b, 10, 1'b0, 3);
    for (int i = 0; i < 64; i++) add_byte(8'(i));
    add_ticks(5);
    wait_drained();

    add_random(3, 3);
    wait_drained();

    // receiver holds off while the sender keeps offering requests
    hold_go = 1'b1;
    add_random(2, 3);
    wait_drained();

    write_reg(REG_SLAVE_ADDR, 8'd255);
    write_reg(REG_GAP_TICKS, 8'd0);
    send_idle_pct = 74; recv_idle_pct = 6;
    add_random(2, 0);
    wait_drained();

    write_reg(REG_SLAVE_ADDR, 8'd0);
    write_reg(REG_GAP_TICKS, 8'd2);
    add_random(1, 2);
    wait_drained();

    write_reg(REG_SLAVE_ADDR, 8'd37);
    write_reg(REG_GAP_TICKS, 8'd1);
    send_idle_pct = 0; recv_idle_pct = 0;
    add_random(3, 1);
    wait_drained();

    gen_done = 1'b1;
    if (errors == 0 && reply_expect.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
